FILE: rtl/sobe_pkg.sv
// Shared types and widths for the sub-octave bass enhancer and its multiply unit.
package sobe_pkg;

	// Default sample width of the audio ports.
	localparam int SAMPLE_WIDTH_DEF = 24;

	// Operand and result widths of the shared multiply unit.
	localparam int OPA_W = 48;
	localparam int OPB_W = 33;
	localparam int RES_W = 50;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_ROOT_GAIN    = 3'd0;
	localparam logic [2:0] REG_SUB_GAIN     = 3'd1;
	localparam logic [2:0] REG_FILTER_COEFF = 3'd2;
	localparam logic [2:0] REG_DC_STEP      = 3'd3;
	localparam logic [2:0] REG_BASS_TRIM    = 3'd4;
	localparam logic [2:0] REG_WET_GAIN     = 3'd5;
	localparam logic [2:0] REG_DRY_GAIN     = 3'd6;
	localparam int         REG_COUNT        = 7;

	// Right shift applied to a finished product.
	typedef enum logic [1:0] {
		SH_15,
		SH_22,
		SH_24
	} shift_t;

	// Request from the sequencer to the multiply unit.
	typedef struct packed {
		logic   start;
		shift_t shift;
	} mul_req_t;

	// Status from the multiply unit back to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} mul_rsp_t;

endpackage

FILE: rtl/sobe_mul.sv
// Two-pass shared multiplier: 48-bit signed by 33-bit signed product, floored right shift.
module sobe_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sobe_pkg::mul_req_t                  req,
	input  logic signed [sobe_pkg::OPA_W-1:0]   a,
	input  logic signed [sobe_pkg::OPB_W-1:0]   b,
	output sobe_pkg::mul_rsp_t                  rsp,
	output logic signed [sobe_pkg::RES_W-1:0]   result
);
	import sobe_pkg::*;

	localparam int SPLIT  = OPA_W / 2;
	localparam int OP_W   = SPLIT + 1;
	localparam int PROD_W = OP_W + OPB_W;
	localparam int ACC_W  = PROD_W + SPLIT;

	typedef enum logic [1:0] {
		M_IDLE,
		M_LO,
		M_HI
	} mstate_t;

	mstate_t                   state_q;
	logic                      done_q;
	shift_t                    shift_q;
	logic signed [OPA_W-1:0]   a_q;
	logic signed [OPB_W-1:0]   b_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [OP_W-1:0]    op;
	logic signed [PROD_W-1:0]  prod;
	logic signed [ACC_W-1:0]   shifted;

	// The low half of the A operand goes in unsigned first, then the signed high half.
	always_comb begin
		if (state_q == M_HI) begin
			op = {a_q[OPA_W-1], a_q[OPA_W-1:SPLIT]};
		end else begin
			op = {1'b0, a_q[SPLIT-1:0]};
		end
		prod = op * b_q;
	end

	// Sequencing of the two passes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (req.start) begin
						state_q <= M_LO;
					end
				end
				M_LO: begin
					state_q <= M_HI;
				end
				M_HI: begin
					state_q <= M_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	// Operands and the accumulated product.
	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && req.start) begin
			a_q     <= a;
			b_q     <= b;
			shift_q <= req.shift;
		end
		if (state_q == M_LO) begin
			acc_q <= {{SPLIT{prod[PROD_W-1]}}, prod};
		end else if (state_q == M_HI) begin
			acc_q <= acc_q + {prod, {SPLIT{1'b0}}};
		end
	end

	// Floored shift of the finished product.
	always_comb begin
		unique case (shift_q)
			SH_15:   shifted = acc_q >>> 15;
			SH_22:   shifted = acc_q >>> 22;
			SH_24:   shifted = acc_q >>> 24;
			default: shifted = acc_q;
		endcase
		result   = shifted[RES_W-1:0];
		rsp.busy = (state_q != M_IDLE);
		rsp.done = done_q;
	end

endmodule

FILE: rtl/sub_octave_bass_enhancer.sv
// Top level of the sub-octave bass enhancer: register port, sequencer and sample datapath.
// A new sample is taken only once the last one is through; the twelve products of each sample run one
// after another through the single shared multiplier, each as issue, two passes and apply.
// Input stall stays high from acceptance until the result is loaded into the output register.
// Reset clears the filter and integrator state, the sub-octave flip-flop and the output
// register, and returns all configuration registers to their reset values.
module sub_octave_bass_enhancer #(
	parameter int SAMPLE_WIDTH = sobe_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [4:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] audio_in,
	input  logic                           block_end,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] audio_out,
	output logic                           block_end_out
);
	import sobe_pkg::*;

	// Sample widened to Q8.24 needs 25 bits.
	localparam int XS_W   = 25;
	localparam int XE_W   = 33;
	localparam int XS_SHL = (SAMPLE_WIDTH < XS_W) ? XS_W - SAMPLE_WIDTH : 0;
	localparam int XS_SHR = (SAMPLE_WIDTH > XS_W) ? SAMPLE_WIDTH - XS_W : 0;
	localparam int SUM_W  = RES_W + 1;
	localparam int FIN_W  = SUM_W + XS_SHR;

	// Register reset values.
	localparam logic [15:0] ROOT_GAIN_RST    = 16'd32768;
	localparam logic [15:0] SUB_GAIN_RST     = 16'd0;
	localparam logic [23:0] FILTER_COEFF_RST = 24'd1174405;
	localparam logic [31:0] DC_STEP_RST      = 32'd24595737;
	localparam logic [23:0] BASS_TRIM_RST    = 24'd4793490;
	localparam logic [15:0] WET_GAIN_RST     = 16'd32768;
	localparam logic [15:0] DRY_GAIN_RST     = 16'd0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENV,
		ST_MAG,
		ST_ROOT,
		ST_INT,
		ST_CUBE1,
		ST_CUBE2,
		ST_CUBE3,
		ST_DC,
		ST_TRIM,
		ST_SM1,
		ST_SM2,
		ST_DRY,
		ST_WET,
		ST_FINISH
	} state_t;

	// Clamp a wide sum to the signed 32-bit state range.
	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-32:0] top;
		top = v[SUM_W-1:31];
		if (&top || ~|top) begin
			return v[31:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {31{1'b0}}};
		end else begin
			return {1'b0, {31{1'b1}}};
		end
	endfunction

	// Configuration registers.
	logic [15:0] root_gain_q;
	logic [15:0] sub_gain_q;
	logic [23:0] filter_coeff_q;
	logic [31:0] dc_step_q;
	logic [23:0] bass_trim_q;
	logic [15:0] wet_gain_q;
	logic [15:0] dry_gain_q;

	// Sequencer and datapath registers.
	state_t                          state_q;
	logic                            pending_q;
	logic                            was_neg_q;
	logic                            phase_q;
	logic signed [31:0]              env_q;
	logic signed [31:0]              integ_q;
	logic signed [31:0]              s1_q;
	logic signed [31:0]              s2_q;
	logic signed [XS_W-1:0]          xs_q;
	logic                            blk_q;
	logic signed [OPA_W-1:0]         t_q;
	logic signed [SAMPLE_WIDTH-1:0]  smp_q;
	logic                            out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0]  audio_out_q;
	logic                            block_end_out_q;

	// Combinational signals.
	logic signed [XE_W-1:0]          x_ext;
	logic signed [XE_W-1:0]          xs_full;
	logic                            x_pos;
	logic signed [OPA_W-1:0]         xs_a;
	logic signed [OPA_W-1:0]         env_a;
	logic signed [OPA_W-1:0]         integ_a;
	logic signed [OPA_W-1:0]         s1_a;
	logic signed [OPA_W-1:0]         s2_a;
	logic signed [OPA_W-1:0]         mul_a;
	logic signed [OPB_W-1:0]         mul_b;
	logic signed [RES_W-1:0]         mul_res;
	mul_req_t                        mul_req;
	mul_rsp_t                        mul_rsp;
	logic                            is_mul_state;
	logic signed [SUM_W-1:0]         r_w;
	logic signed [SUM_W-1:0]         upd_base;
	logic                            upd_sub;
	logic signed [SUM_W-1:0]         upd_sum;
	logic signed [31:0]              upd_sat;
	logic signed [SUM_W-1:0]         integ_w;
	logic signed [SUM_W-1:0]         dc_w;
	logic signed [SUM_W-1:0]         dc_sum;
	logic signed [31:0]              dc_sat;
	logic signed [SUM_W-1:0]         fin_sum;
	logic signed [FIN_W-1:0]         fin_ext;
	logic signed [FIN_W-1:0]         fin_scaled;
	logic [FIN_W-SAMPLE_WIDTH:0]     fin_top;
	logic signed [SAMPLE_WIDTH-1:0]  fin_sat;

	assign pready        = 1'b1;
	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign audio_out     = audio_out_q;
	assign block_end_out = block_end_out_q;

	// Register writes; a write beyond the last register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_gain_q    <= ROOT_GAIN_RST;
			sub_gain_q     <= SUB_GAIN_RST;
			filter_coeff_q <= FILTER_COEFF_RST;
			dc_step_q      <= DC_STEP_RST;
			bass_trim_q    <= BASS_TRIM_RST;
			wet_gain_q     <= WET_GAIN_RST;
			dry_gain_q     <= DRY_GAIN_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:2])
				REG_ROOT_GAIN:    root_gain_q    <= pwdata[15:0];
				REG_SUB_GAIN:     sub_gain_q     <= pwdata[15:0];
				REG_FILTER_COEFF: filter_coeff_q <= pwdata[23:0];
				REG_DC_STEP:      dc_step_q      <= pwdata;
				REG_BASS_TRIM:    bass_trim_q    <= pwdata[23:0];
				REG_WET_GAIN:     wet_gain_q     <= pwdata[15:0];
				REG_DRY_GAIN:     dry_gain_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[4:2])
			REG_ROOT_GAIN:    prdata = {16'd0, root_gain_q};
			REG_SUB_GAIN:     prdata = {16'd0, sub_gain_q};
			REG_FILTER_COEFF: prdata = {8'd0, filter_coeff_q};
			REG_DC_STEP:      prdata = dc_step_q;
			REG_BASS_TRIM:    prdata = {8'd0, bass_trim_q};
			REG_WET_GAIN:     prdata = {16'd0, wet_gain_q};
			REG_DRY_GAIN:     prdata = {16'd0, dry_gain_q};
			default:          prdata = 32'd0;
		endcase
	end

	// Input sample widened to Q8.24, and its sign for the crossing detector.
	always_comb begin
		x_ext   = {{(XE_W-SAMPLE_WIDTH){audio_in[SAMPLE_WIDTH-1]}}, audio_in};
		xs_full = (x_ext <<< XS_SHL) >>> XS_SHR;
		x_pos   = !audio_in[SAMPLE_WIDTH-1] && (|audio_in);
	end

	// State values widened to the multiplier's A operand.
	always_comb begin
		xs_a    = {{(OPA_W-XS_W){xs_q[XS_W-1]}}, xs_q};
		env_a   = {{(OPA_W-32){env_q[31]}}, env_q};
		integ_a = {{(OPA_W-32){integ_q[31]}}, integ_q};
		s1_a    = {{(OPA_W-32){s1_q[31]}}, s1_q};
		s2_a    = {{(OPA_W-32){s2_q[31]}}, s2_q};
	end

	// Operand selection for the product of the current step.
	always_comb begin
		mul_a         = '0;
		mul_b         = '0;
		mul_req.shift = SH_22;
		is_mul_state  = 1'b1;
		unique case (state_q)
			ST_ENV: begin
				mul_a = xs_a - env_a;
				mul_b = {{(OPB_W-24){1'b0}}, filter_coeff_q};
			end
			ST_MAG: begin
				mul_a         = env_q[31] ? -env_a : env_a;
				mul_b         = {{(OPB_W-16){1'b0}}, sub_gain_q};
				mul_req.shift = SH_15;
			end
			ST_ROOT: begin
				mul_a         = xs_a;
				mul_b         = {{(OPB_W-16){1'b0}}, root_gain_q};
				mul_req.shift = SH_15;
			end
			ST_INT: begin
				mul_a = t_q;
				mul_b = {{(OPB_W-24){1'b0}}, filter_coeff_q};
			end
			ST_CUBE1: begin
				mul_a         = integ_a;
				mul_b         = {integ_q[31], integ_q};
				mul_req.shift = SH_24;
			end
			ST_CUBE2: begin
				mul_a         = t_q;
				mul_b         = {integ_q[31], integ_q};
				mul_req.shift = SH_24;
			end
			ST_CUBE3: begin
				mul_a = t_q;
				mul_b = {{(OPB_W-24){1'b0}}, filter_coeff_q};
			end
			ST_TRIM: begin
				mul_a = integ_a;
				mul_b = {{(OPB_W-24){1'b0}}, bass_trim_q};
			end
			ST_SM1: begin
				mul_a = t_q - s1_a;
				mul_b = {{(OPB_W-24){1'b0}}, filter_coeff_q};
			end
			ST_SM2: begin
				mul_a = s1_a - s2_a;
				mul_b = {{(OPB_W-24){1'b0}}, filter_coeff_q};
			end
			ST_DRY: begin
				mul_a         = xs_a;
				mul_b         = {{(OPB_W-16){1'b0}}, dry_gain_q};
				mul_req.shift = SH_15;
			end
			ST_WET: begin
				mul_a         = s2_a;
				mul_b         = {{(OPB_W-16){1'b0}}, wet_gain_q};
				mul_req.shift = SH_15;
			end
			default: begin
				is_mul_state = 1'b0;
			end
		endcase
		mul_req.start = is_mul_state && !pending_q;
	end

	sobe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.a      (mul_a),
		.b      (mul_b),
		.rsp    (mul_rsp),
		.result (mul_res)
	);

	// State update: one saturating adder shared by the filter and integrator steps.
	always_comb begin
		r_w      = {mul_res[RES_W-1], mul_res};
		integ_w  = {{(SUM_W-32){integ_q[31]}}, integ_q};
		upd_sub  = 1'b0;
		unique case (state_q)
			ST_ENV:   upd_base = {{(SUM_W-32){env_q[31]}}, env_q};
			ST_SM1:   upd_base = {{(SUM_W-32){s1_q[31]}}, s1_q};
			ST_SM2:   upd_base = {{(SUM_W-32){s2_q[31]}}, s2_q};
			ST_CUBE3: begin
				upd_base = integ_w;
				upd_sub  = 1'b1;
			end
			default:  upd_base = integ_w;
		endcase
		upd_sum = upd_sub ? upd_base - r_w : upd_base + r_w;
		upd_sat = sat32(upd_sum);
	end

	// Constant pull of the integrator toward zero.
	always_comb begin
		dc_w = {{(SUM_W-24){1'b0}}, dc_step_q[31:8]};
		if (!integ_q[31] && (|integ_q)) begin
			dc_sum = integ_w - dc_w;
		end else begin
			dc_sum = integ_w + dc_w;
		end
		dc_sat = sat32(dc_sum);
	end

	// Dry plus wet, back to sample format, saturated.
	always_comb begin
		fin_sum    = {{(SUM_W-OPA_W){t_q[OPA_W-1]}}, t_q} + r_w;
		fin_ext    = {{(FIN_W-SUM_W){fin_sum[SUM_W-1]}}, fin_sum};
		fin_scaled = (fin_ext <<< XS_SHR) >>> XS_SHL;
		fin_top    = fin_scaled[FIN_W-1:SAMPLE_WIDTH-1];
		if (&fin_top || ~|fin_top) begin
			fin_sat = fin_scaled[SAMPLE_WIDTH-1:0];
		end else if (fin_scaled[FIN_W-1]) begin
			fin_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			fin_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end
	end

	// Sequencer, sample state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			pending_q       <= 1'b0;
			was_neg_q       <= 1'b0;
			phase_q         <= 1'b0;
			env_q           <= '0;
			integ_q         <= '0;
			s1_q            <= '0;
			s2_q            <= '0;
			xs_q            <= '0;
			blk_q           <= 1'b0;
			t_q             <= '0;
			smp_q           <= '0;
			out_valid_q     <= 1'b0;
			audio_out_q     <= '0;
			block_end_out_q <= 1'b0;
		end else begin
			// The final step loads a new word, or the downstream side takes the waiting one.
			if (state_q == ST_FINISH && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			// Issue tracking for the shared multiplier.
			if (mul_rsp.done) begin
				pending_q <= 1'b0;
			end else if (mul_req.start) begin
				pending_q <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						xs_q  <= xs_full[XS_W-1:0];
						blk_q <= block_end;
						// The square flips on each rise from non-positive to positive.
						if (x_pos) begin
							if (was_neg_q) begin
								phase_q <= !phase_q;
							end
							was_neg_q <= 1'b0;
						end else begin
							was_neg_q <= 1'b1;
						end
						state_q <= ST_ENV;
					end
				end
				ST_ENV: begin
					if (mul_rsp.done) begin
						env_q   <= upd_sat;
						state_q <= ST_MAG;
					end
				end
				ST_MAG: begin
					if (mul_rsp.done) begin
						t_q     <= mul_res[OPA_W-1:0];
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (mul_rsp.done) begin
						t_q     <= (phase_q ? t_q : -t_q) + mul_res[OPA_W-1:0];
						state_q <= ST_INT;
					end
				end
				ST_INT: begin
					if (mul_rsp.done) begin
						integ_q <= upd_sat;
						state_q <= ST_CUBE1;
					end
				end
				ST_CUBE1: begin
					if (mul_rsp.done) begin
						t_q     <= mul_res[OPA_W-1:0];
						state_q <= ST_CUBE2;
					end
				end
				ST_CUBE2: begin
					if (mul_rsp.done) begin
						t_q     <= mul_res[OPA_W-1:0];
						state_q <= ST_CUBE3;
					end
				end
				ST_CUBE3: begin
					if (mul_rsp.done) begin
						integ_q <= upd_sat;
						state_q <= ST_DC;
					end
				end
				ST_DC: begin
					integ_q <= dc_sat;
					state_q <= ST_TRIM;
				end
				ST_TRIM: begin
					if (mul_rsp.done) begin
						t_q     <= mul_res[OPA_W-1:0];
						state_q <= ST_SM1;
					end
				end
				ST_SM1: begin
					if (mul_rsp.done) begin
						s1_q    <= upd_sat;
						state_q <= ST_SM2;
					end
				end
				ST_SM2: begin
					if (mul_rsp.done) begin
						s2_q    <= upd_sat;
						state_q <= ST_DRY;
					end
				end
				ST_DRY: begin
					if (mul_rsp.done) begin
						t_q     <= mul_res[OPA_W-1:0];
						state_q <= ST_WET;
					end
				end
				ST_WET: begin
					if (mul_rsp.done) begin
						smp_q   <= fin_sat;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// Load the output register once it is free or being emptied.
					if (!out_valid_q || !out_stall) begin
						audio_out_q     <= smp_q;
						block_end_out_q <= blk_q;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The multiplier is only started when it is free.
	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |-> !mul_rsp.busy)
		else $error("multiplier started while busy");

	// Every finished product belongs to an issued step.
	a_done_pending: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> pending_q)
		else $error("product finished with no step waiting");

	// An accepted word closes the input right after its acceptance.
	a_accept_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input open right after acceptance");

	// A new output word only comes from the final step.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FINISH))
		else $error("output word raised outside the final step");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the sub-octave bass enhancer: directed table, random phases, predictor.
`timescale 1ns / 100ps

module testbench;

	import sobe_pkg::*;

	localparam int SW = SAMPLE_WIDTH_DEF;

	// Kinds of random waveform.
	localparam int WAVE_SQUARE = 0;
	localparam int WAVE_NOISE  = 1;
	localparam int WAVE_QUIET  = 2;
	localparam int WAVE_EDGE   = 3;

	typedef logic signed [SW-1:0] sample_t;
	typedef logic signed [127:0]  wide_t;
	typedef logic signed [31:0]   q8_24_t;

	typedef struct packed {
		sample_t audio;
		logic    be;
	} out_word_t;

	typedef struct packed {
		sample_t sample;
		logic    be;
		logic    typed;
		sample_t word;
	} stim_row_t;

	localparam wide_t Q_MAX = wide_t'(32'sh7fffffff);
	localparam wide_t Q_MIN = wide_t'(32'sh80000000);

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	sample_t     audio_in;
	logic        block_end;
	logic        out_valid;
	logic        out_stall = 1'b0;
	sample_t     audio_out;
	logic        block_end_out;

	// Testbench side information that travels with each input word.
	logic        pin_valid;
	sample_t     pin_word;
	logic        idle_en = 1'b1;

	// Predicted configuration and state of the block.
	logic [31:0] cfg [REG_COUNT];
	logic        was_negative = 1'b0;
	logic        sub_phase = 1'b0;
	q8_24_t      envelope = '0;
	q8_24_t      integ = '0;
	q8_24_t      smooth_a = '0;
	q8_24_t      smooth_b = '0;

	out_word_t   expected_out [$];
	int          mismatches = 0;
	stim_row_t   stim_table [24];

	sub_octave_bass_enhancer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.audio_in     (audio_in),
		.block_end    (block_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.audio_out    (audio_out),
		.block_end_out(block_end_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The run is cut off if the block stops answering.
	initial begin
		#10_000_000;
		$display("Timeout: the block stopped moving words");
		$display("Verification failed");
		$finish;
	end

	function automatic logic [31:0] reg_mask(int idx);
		case (idx)
			REG_FILTER_COEFF, REG_BASS_TRIM: return 32'h00FFFFFF;
			REG_DC_STEP:                     return 32'hFFFFFFFF;
			REG_ROOT_GAIN, REG_SUB_GAIN,
			REG_WET_GAIN, REG_DRY_GAIN:      return 32'h0000FFFF;
			default:                         return 32'h0;
		endcase
	endfunction

	function automatic wide_t widen_u(logic [31:0] v);
		return $signed({96'd0, v});
	endfunction

	// Exact floor of a * b / 2^s.
	function automatic wide_t mul_shift(wide_t a, wide_t b, int s);
		wide_t p;
		p = a * b;
		return p >>> s;
	endfunction

	function automatic q8_24_t clamp_q(wide_t v);
		if (v > Q_MAX) return q8_24_t'(Q_MAX);
		if (v < Q_MIN) return q8_24_t'(Q_MIN);
		return q8_24_t'(v);
	endfunction

	function automatic q8_24_t one_pole(q8_24_t y, wide_t target, wide_t c);
		return clamp_q(wide_t'(y) + mul_shift(target - wide_t'(y), c, 22));
	endfunction

	// Computes the enhanced output sample for one input and advances the predicted state.
	function automatic sample_t enhance_sample(sample_t x);
		wide_t xs, mag, mix, cube, trimmed, acc, c, dc, s_max, s_min;
		c = widen_u(cfg[REG_FILTER_COEFF]);
		dc = widen_u(cfg[REG_DC_STEP] >> 8);
		xs = wide_t'(x) <<< (25 - SW);

		// A zero sample counts as not positive.
		if (x > 0) begin
			if (was_negative) sub_phase = ~sub_phase;
			was_negative = 1'b0;
		end else begin
			was_negative = 1'b1;
		end

		envelope = one_pole(envelope, xs, c);
		mag = (envelope < 0) ? -wide_t'(envelope) : wide_t'(envelope);
		mag = mul_shift(mag, widen_u(cfg[REG_SUB_GAIN]), 15);
		mix = (sub_phase ? mag : -mag) + mul_shift(xs, widen_u(cfg[REG_ROOT_GAIN]), 15);

		// Leaky integrator with the cubic limit and the pull toward zero.
		integ = clamp_q(wide_t'(integ) + mul_shift(mix, c, 22));
		cube = mul_shift(wide_t'(integ), wide_t'(integ), 24);
		cube = mul_shift(cube, wide_t'(integ), 24);
		integ = clamp_q(wide_t'(integ) - mul_shift(cube, c, 22));
		if (integ > 0) integ = clamp_q(wide_t'(integ) - dc);
		else integ = clamp_q(wide_t'(integ) + dc);

		trimmed = mul_shift(wide_t'(integ), widen_u(cfg[REG_BASS_TRIM]), 22);
		smooth_a = one_pole(smooth_a, trimmed, c);
		smooth_b = one_pole(smooth_b, wide_t'(smooth_a), c);

		// Wet and dry blend, back to sample format with saturation.
		acc = mul_shift(xs, widen_u(cfg[REG_DRY_GAIN]), 15)
			+ mul_shift(wide_t'(smooth_b), widen_u(cfg[REG_WET_GAIN]), 15);
		acc = acc >>> (25 - SW);
		s_max = (wide_t'(1) <<< (SW - 1)) - 1;
		s_min = -(wide_t'(1) <<< (SW - 1));
		if (acc > s_max) acc = s_max;
		if (acc < s_min) acc = s_min;
		return sample_t'(acc);
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t ns: %s", $realtime, msg);
		mismatches++;
	endtask

	// Checks register reads and result words, and predicts a result for each accepted word.
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n) begin
			if (psel && penable && !pwrite && pready) begin
				if (prdata !== cfg[paddr[4:2]])
					report_mismatch($sformatf("register %0d read %h, predicted %h",
						paddr[4:2], prdata, cfg[paddr[4:2]]));
			end
			if (out_valid && !out_stall) begin
				if (expected_out.size() == 0) begin
					report_mismatch($sformatf("result word %0d with nothing pending",
						audio_out));
				end else begin
					want = expected_out.pop_front();
					if (audio_out !== want.audio)
						report_mismatch($sformatf("audio_out %0d, predicted %0d",
							audio_out, want.audio));
					if (block_end_out !== want.be)
						report_mismatch($sformatf("block_end_out %b, predicted %b",
							block_end_out, want.be));
				end
			end
			if (in_valid && !in_stall) begin
				want.audio = enhance_sample(audio_in);
				want.be = block_end;
				if (pin_valid) want.audio = pin_word;
				expected_out.push_back(want);
			end
		end
	end

	// The result side stalls at random while idling is enabled.
	always @(negedge clk) out_stall <= idle_en && ($urandom_range(99) < 23);

	// Drops valid and waits until every pending result word has come out.
	task automatic pause_input();
		in_valid <= 1'b0;
		do @(negedge clk); while (expected_out.size() != 0);
	endtask

	// Writes a register and, when the index exists, reads it back.
	task automatic config_reg(int idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx * 4);
		pwdata <= value;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx < REG_COUNT) cfg[idx] = value & reg_mask(idx);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		if (idx < REG_COUNT) begin
			psel <= 1'b1;
			pwrite <= 1'b0;
			@(negedge clk) penable <= 1'b1;
			do @(posedge clk); while (!pready);
			@(negedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
			@(negedge clk);
		end
	endtask

	// Offers one input word, after an optional gap, and returns at the falling edge after it is accepted.
	task automatic send_word(sample_t s, logic be, logic pinned, sample_t pin,
		logic drain_first);
		int gap;
		gap = 0;
		if (drain_first) gap = 1;
		else if (idle_en && $urandom_range(99) < 30) gap = $urandom_range(1, 70);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
			if (drain_first) while (expected_out.size() != 0) @(negedge clk);
		end
		in_valid <= 1'b1;
		audio_in <= s;
		block_end <= be;
		pin_valid <= pinned;
		pin_word <= pin;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	initial begin
		int i, r, ph, n, roll, mode, run_left, half, tick;
		int sel;
		logic [31:0] v;
		sample_t amp, s;

		arst_n = 1'b0;
		in_valid = 1'b0;
		audio_in = '0;
		block_end = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pin_valid = 1'b0;
		pin_word = '0;
		cfg[REG_ROOT_GAIN] = 32'd32768;
		cfg[REG_SUB_GAIN] = 32'd0;
		cfg[REG_FILTER_COEFF] = 32'd1174405;
		cfg[REG_DC_STEP] = 32'd24595737;
		cfg[REG_BASS_TRIM] = 32'd4793490;
		cfg[REG_WET_GAIN] = 32'd32768;
		cfg[REG_DRY_GAIN] = 32'd0;

		// Rows 0-7 run on the reset settings, 8-13 pass the input straight through,
		// 14-17 run with every register at zero and 18-23 with every register at its top.
		stim_table = '{
			'{24'sd0,       1'b0, 1'b0, 24'sd0},
			'{24'sh7FFFFF,  1'b0, 1'b0, 24'sd0},
			'{24'sh800000,  1'b1, 1'b0, 24'sd0},
			'{24'sd1,       1'b0, 1'b0, 24'sd0},
			'{-24'sd1,      1'b0, 1'b0, 24'sd0},
			'{24'sd0,       1'b0, 1'b0, 24'sd0},
			'{24'sh400000,  1'b0, 1'b0, 24'sd0},
			'{-24'sh400000, 1'b1, 1'b0, 24'sd0},
			'{24'sh800000,  1'b0, 1'b1, 24'sh800000},
			'{24'sh7FFFFF,  1'b0, 1'b1, 24'sh7FFFFF},
			'{24'sh555555,  1'b1, 1'b1, 24'sh555555},
			'{24'shAAAAAA,  1'b0, 1'b1, 24'shAAAAAA},
			'{24'sd0,       1'b0, 1'b1, 24'sd0},
			'{24'sd1,       1'b1, 1'b1, 24'sd1},
			'{24'sh7FFFFF,  1'b0, 1'b1, 24'sd0},
			'{24'sh800000,  1'b1, 1'b1, 24'sd0},
			'{-24'sd1,      1'b0, 1'b1, 24'sd0},
			'{24'sd0,       1'b0, 1'b1, 24'sd0},
			'{24'sh7FFFFF,  1'b0, 1'b0, 24'sd0},
			'{24'sh800000,  1'b0, 1'b0, 24'sd0},
			'{24'sh7FFFFF,  1'b1, 1'b0, 24'sd0},
			'{24'sh800000,  1'b0, 1'b0, 24'sd0},
			'{24'sd0,       1'b0, 1'b0, 24'sd0},
			'{24'sd1,       1'b1, 1'b0, 24'sd0}
		};

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table, with the settings changed between its sections.
		for (i = 0; i < 24; i++) begin
			if (i == 8 || i == 14 || i == 18) begin
				pause_input();
				case (i)
					8: begin
						config_reg(REG_WET_GAIN, 32'd0);
						config_reg(REG_DRY_GAIN, 32'd32768);
						// A write past the last register must change nothing.
						config_reg(REG_COUNT, $urandom());
					end
					14: for (r = 0; r < REG_COUNT; r++) config_reg(r, 32'd0);
					default: for (r = 0; r < REG_COUNT; r++) config_reg(r, 32'hFFFFFFFF);
				endcase
			end
			send_word(stim_table[i].sample, stim_table[i].be, stim_table[i].typed,
				stim_table[i].word, 1'b0);
		end

		// Random phases, each with fresh settings; phase four runs with no idling at all.
		run_left = 0;
		mode = WAVE_NOISE;
		half = 1;
		tick = 0;
		amp = 24'sd1;
		for (ph = 0; ph < 10; ph++) begin
			pause_input();
			idle_en = (ph != 4);
			for (r = 0; r < REG_COUNT; r++) begin
				sel = $urandom_range(9);
				if (sel == 0) begin
					v = 32'd0;
				end else if (sel == 1) begin
					v = 32'hFFFFFFFF;
				end else begin
					case (r)
						REG_FILTER_COEFF: v = $urandom_range(0, 4194304);
						REG_DC_STEP:      v = $urandom() >> $urandom_range(0, 31);
						REG_BASS_TRIM:    v = $urandom_range(0, 8388608);
						default:          v = $urandom_range(0, 32768);
					endcase
				end
				// Bits above the register width must be dropped by the block.
				if (sel != 1) v = v | ($urandom() & ~reg_mask(r));
				config_reg(r, v);
			end
			for (n = 0; n < 125; n++) begin
				if (run_left == 0) begin
					roll = $urandom_range(99);
					if (roll < 40) mode = WAVE_SQUARE;
					else if (roll < 70) mode = WAVE_NOISE;
					else if (roll < 85) mode = WAVE_QUIET;
					else mode = WAVE_EDGE;
					run_left = $urandom_range(10, 60);
					amp = sample_t'($urandom_range(1, 8388607));
					half = $urandom_range(1, 40);
					tick = 0;
				end
				case (mode)
					WAVE_SQUARE: begin
						s = ((tick / half) % 2 == 1) ? -amp : amp;
						tick++;
					end
					WAVE_NOISE: s = sample_t'($urandom());
					WAVE_QUIET: s = sample_t'($urandom_range(0, 16)) - 8;
					default: begin
						case ($urandom_range(4))
							0: s = 24'sh7FFFFF;
							1: s = 24'sh800000;
							2: s = 24'sd0;
							3: s = 24'sd1;
							default: s = -24'sd1;
						endcase
					end
				endcase
				run_left--;
				send_word(s, ($urandom_range(7) == 0), 1'b0, 24'sd0,
					($urandom_range(99) < 3));
			end
		end

		// Let the last words drain, then allow for the block's latency.
		pause_input();
		repeat (60) @(negedge clk);
		if (mismatches == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/sobe_pkg.sv
rtl/sobe_mul.sv
rtl/sub_octave_bass_enhancer.sv
tb/testbench.sv
